// ----- design/iiut_pkg.sv -----
// Shared types and constants for the upright/tilted integral image block.
package iiut_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 16;
    localparam int CSUM_W     = 28;
    localparam int SUM_W      = 38;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MODE_W     = 2;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    localparam logic [CFG_ADDR_W-1:0] CFG_SUM_MODE     = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = CFG_ADDR_W'(2);

    localparam int MODE_SQUARED_BIT = 0;
    localparam int MODE_TILTED_BIT  = 1;

    typedef struct packed {
        logic squared;
        logic tilted;
        logic first_col;
        logic row_ge1;
        logic row_ge2;
        logic has_right;
        logic frame_end;
    } iiut_ctrl_t;

    // One line-buffer entry per column.
    typedef struct packed {
        logic [CSUM_W-1:0] csum;
        logic [PIX_W-1:0]  pix;
        logic [SQ_W-1:0]   sq;
        logic [SUM_W-1:0]  prev_d;
        logic [SUM_W-1:0]  older_d;
    } iiut_entry_t;

endpackage

// ----- design/iiut_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module iiut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/iiut_fifo.sv -----
// Small register queue between the front and back parts.
module iiut_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/iiut_front.sv -----
// Front part: configuration registers, pixel position counters, term and flag generation.
module iiut_front
    import iiut_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [CFG_ADDR_W-1:0]           cfg_addr,
    input  logic [CFG_DATA_W-1:0]           cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [PIX_W-1:0]                s_pix,
    output logic                            q_valid,
    input  logic                            q_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]    q_col,
    output logic [$clog2(MAX_WIDTH)-1:0]    q_nxt,
    output logic [PIX_W-1:0]                q_pix,
    output logic [SQ_W-1:0]                 q_sq,
    output iiut_ctrl_t                      q_ctrl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [MODE_W-1:0] mode_reg;
    logic [CW-1:0]     w_last_reg;
    logic [RW-1:0]     h_last_reg;
    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    logic              row_end;
    logic              frame_end;
    logic              accept;

    function automatic logic [CW-1:0] w_last_of(input logic [FW_W-1:0] fw);
        int v;
        v = int'(fw);
        if (v < 2) begin
            v = 2;
        end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
        end
        return CW'(v - 1);
    endfunction

    function automatic logic [RW-1:0] h_last_of(input logic [FH_W-1:0] fh);
        int v;
        v = int'(fh);
        if (v < 1) begin
            v = 1;
        end else if (v > MAX_HEIGHT) begin
            v = MAX_HEIGHT;
        end
        return RW'(v - 1);
    endfunction

    assign accept    = s_tvalid && q_ready;
    assign s_tready  = q_ready;
    assign q_valid   = s_tvalid;
    assign row_end   = (col_reg >= w_last_reg);
    assign frame_end = row_end && (row_reg >= h_last_reg);

    assign q_col = col_reg;
    assign q_nxt = row_end ? '0 : col_reg + 1'b1;
    assign q_pix = s_pix;
    assign q_sq  = SQ_W'(s_pix * s_pix);

    always_comb begin
        q_ctrl.squared   = mode_reg[MODE_SQUARED_BIT];
        q_ctrl.tilted    = mode_reg[MODE_TILTED_BIT];
        q_ctrl.first_col = (col_reg == '0);
        q_ctrl.row_ge1   = (row_reg != '0);
        q_ctrl.row_ge2   = (row_reg > RW'(1));
        q_ctrl.has_right = !row_end;
        q_ctrl.frame_end = frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            w_last_reg <= w_last_of(FW_RESET);
            h_last_reg <= h_last_of(FH_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SUM_MODE: begin
                    mode_reg <= cfg_wdata[MODE_W-1:0];
                end
                CFG_FRAME_WIDTH: begin
                    w_last_reg <= w_last_of(cfg_wdata[FW_W-1:0]);
                end
                CFG_FRAME_HEIGHT: begin
                    h_last_reg <= h_last_of(cfg_wdata[FH_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

endmodule

// ----- design/iiut_back.sv -----
// Back part: line-buffer access, upright and tilted sums, output register.
module iiut_back
    import iiut_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_nxt,
    input  logic [PIX_W-1:0]              q_pix,
    input  logic [SQ_W-1:0]               q_sq,
    input  iiut_ctrl_t                    q_ctrl,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [SUM_W-1:0]              m_value,
    output logic                          m_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $bits(iiut_entry_t);

    // stage A
    logic              a_valid_reg;
    logic [CW-1:0]     a_col_reg;
    logic [CSUM_W-1:0] a_csum_reg;
    logic [SUM_W-1:0]  a_s1_reg;
    logic [PIX_W-1:0]  a_pix_reg;
    logic [SQ_W-1:0]   a_sq_reg;
    logic              a_has_b_reg;
    logic              a_first_reg;
    logic              a_tilted_reg;
    logic              a_last_reg;
    logic [SUM_W-1:0]  last_p_reg;

    // output stage
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_value_reg;
    logic              out_last_reg;
    logic [SUM_W-1:0]  rs_reg;

    // read bypass for same-address read and write
    logic              byp_reg;
    logic [EW-1:0]     byp_data_reg;

    logic              pop;
    logic              a_adv;
    logic [EW-1:0]     ram_rdata;
    iiut_entry_t       cur;
    iiut_entry_t       wr_entry;
    logic [SQ_W-1:0]   t;
    logic [SQ_W-1:0]   e;
    logic [CSUM_W-1:0] csum_next;
    logic [SUM_W-1:0]  s1_next;
    logic [SUM_W-1:0]  d_next;
    logic [SUM_W-1:0]  rs_next;

    assign a_adv   = a_valid_reg && (!out_valid_reg || m_tready);
    assign q_ready = !a_valid_reg || a_adv;
    assign pop     = q_valid && q_ready;

    assign cur = iiut_entry_t'(byp_reg ? byp_data_reg : ram_rdata);

    always_comb begin
        t         = q_ctrl.squared ? q_sq : SQ_W'(q_pix);
        e         = q_ctrl.squared ? cur.sq : SQ_W'(cur.pix);
        csum_next = q_ctrl.row_ge1 ? CSUM_W'(cur.csum + CSUM_W'(t)) : CSUM_W'(t);
        s1_next   = ((q_ctrl.row_ge1 && !q_ctrl.first_col) ? last_p_reg : '0)
                  - (q_ctrl.row_ge2 ? cur.older_d : '0)
                  + SUM_W'(t)
                  + (q_ctrl.row_ge1 ? SUM_W'(e) : '0);
    end

    always_comb begin
        d_next  = a_s1_reg + (a_has_b_reg ? cur.prev_d : '0);
        rs_next = (a_first_reg ? '0 : rs_reg) + SUM_W'(a_csum_reg);
        wr_entry.csum    = a_csum_reg;
        wr_entry.pix     = a_pix_reg;
        wr_entry.sq      = a_sq_reg;
        wr_entry.prev_d  = d_next;
        wr_entry.older_d = last_p_reg;
    end

    iiut_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (a_adv),
        .waddr (a_col_reg),
        .wdata (wr_entry),
        .re    (pop),
        .raddr (q_nxt),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (pop) begin
            byp_data_reg <= wr_entry;
            a_col_reg    <= q_col;
            a_csum_reg   <= csum_next;
            a_s1_reg     <= s1_next;
            a_pix_reg    <= q_pix;
            a_sq_reg     <= q_sq;
            a_has_b_reg  <= q_ctrl.row_ge1 && q_ctrl.has_right;
            a_first_reg  <= q_ctrl.first_col;
            a_tilted_reg <= q_ctrl.tilted;
            a_last_reg   <= q_ctrl.frame_end;
            last_p_reg   <= cur.prev_d;
        end
        if (a_adv) begin
            out_value_reg <= a_tilted_reg ? d_next : rs_next;
            out_last_reg  <= a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
            rs_reg        <= '0;
        end else begin
            if (pop) begin
                byp_reg <= a_adv && (q_nxt == a_col_reg);
            end
            if (pop) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                out_valid_reg <= 1'b1;
                rs_reg        <= rs_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_last   = out_last_reg;

endmodule

// ----- design/integral_image_upright_and_tilted.sv -----
// Top level of the streaming upright/tilted integral image block.
// Pixels arrive in raster order, one request per clock while s_tready is high, and each
// gives one 38-bit integral value, upright or 45-degree tilted, of pixels or squared
// pixels. The block sustains one pixel per clock while m_tready is not held low; a pixel
// passes through the queue between the front and back parts and the sum stage before its
// result reaches the output register. The line buffer holds one memory entry per column,
// read one column ahead through a single registered read port, and written back once the
// tilted sum is complete. Frame size and mode are to be written only between requests;
// the block itself does not enforce this. The line buffer needs no clearing.
module integral_image_upright_and_tilted
    import iiut_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [37:0] integral_value, [39:38] zero
    output logic                  m_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = 2 * CW + PIX_W + SQ_W + $bits(iiut_ctrl_t);

    logic             f_valid;
    logic             f_ready;
    logic [CW-1:0]    f_col;
    logic [CW-1:0]    f_nxt;
    logic [PIX_W-1:0] f_pix;
    logic [SQ_W-1:0]  f_sq;
    iiut_ctrl_t       f_ctrl;

    logic             b_valid;
    logic             b_ready;
    logic [QW-1:0]    b_data;
    logic [CW-1:0]    b_col;
    logic [CW-1:0]    b_nxt;
    logic [PIX_W-1:0] b_pix;
    logic [SQ_W-1:0]  b_sq;
    iiut_ctrl_t       b_ctrl;
    logic [SUM_W-1:0] m_value;

    iiut_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pix     (s_tdata[PIX_W-1:0]),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_col     (f_col),
        .q_nxt     (f_nxt),
        .q_pix     (f_pix),
        .q_sq      (f_sq),
        .q_ctrl    (f_ctrl)
    );

    iiut_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_col, f_nxt, f_pix, f_sq, f_ctrl}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_col, b_nxt, b_pix, b_sq, b_ctrl} = b_data;

    iiut_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_col    (b_col),
        .q_nxt    (b_nxt),
        .q_pix    (b_pix),
        .q_sq     (b_sq),
        .q_ctrl   (b_ctrl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_value),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - SUM_W){1'b0}}, m_value};

endmodule
